// ===== rtl/core/hcfb_pkg.sv =====
// Package with shared types, codes and the result decoder of the frame builder.
`timescale 1ns / 1ps

package hcfb_pkg;

  localparam int QueueDepthDefault = 2;
  localparam int IdxW = 3;

  localparam logic [1:0] OP_START  = 2'd0;
  localparam logic [1:0] OP_DATA   = 2'd1;
  localparam logic [1:0] OP_LAST   = 2'd2;
  localparam logic [1:0] OP_REJECT = 2'd3;

  localparam logic [7:0] BYTE_ZERO = 8'h00;
  localparam logic [7:0] BYTE_FF   = 8'hFF;
  localparam logic [7:0] BYTE_DIR  = 8'hD4;

  typedef struct packed {
    logic [1:0] op;
    logic [7:0] value;
    logic [7:0] check;
  } cmd_t;

  typedef struct packed {
    logic [7:0] frame_byte;
    logic       run_last;
    logic       frame_done;
    logic       error;
  } res_t;

  function automatic logic [7:0] twos_neg(input logic [7:0] v);
    return (~v) + 8'd1;
  endfunction

  function automatic res_t result_of(input cmd_t c, input logic [IdxW-1:0] idx);
    res_t r;
    r = '0;
    unique case (c.op)
      OP_START: begin
        case (idx)
          3'd0, 3'd1: r.frame_byte = BYTE_ZERO;
          3'd2: r.frame_byte = BYTE_FF;
          3'd3: r.frame_byte = c.value;
          3'd4: r.frame_byte = c.check;
          default: begin
            r.frame_byte = BYTE_DIR;
            r.run_last   = 1'b1;
          end
        endcase
      end
      OP_DATA: begin
        r.frame_byte = c.value;
        r.run_last   = 1'b1;
      end
      OP_LAST: begin
        case (idx)
          3'd0: r.frame_byte = c.value;
          3'd1: r.frame_byte = c.check;
          default: begin
            r.frame_byte = BYTE_ZERO;
            r.run_last   = 1'b1;
            r.frame_done = 1'b1;
          end
        endcase
      end
      default: begin
        r.frame_byte = BYTE_ZERO;
        r.run_last   = 1'b1;
        r.error      = 1'b1;
      end
    endcase
    return r;
  endfunction

endpackage

// ===== rtl/core/host_command_frame_builder.sv =====
// Top level of the host command frame builder.
// The first byte of an item passes the queue and then the output register.
// Up to one input transfer per cycle while the queue has room; the sequencer emits one
// byte per cycle while the output is not stalled, so a start item makes six bytes, a closing
// data item three, others one.
// Reset (synchronous, active high) closes any open frame and empties the queue.
`timescale 1ns / 1ps

module host_command_frame_builder
  import hcfb_pkg::*;
#(
  parameter int QUEUE_DEPTH = QueueDepthDefault
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [15:0] s_tdata,  // [7:0] payload_length, [15:8] data_byte
  input  logic        s_tuser,  // [0] kind
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [7:0]  m_tdata,  // [7:0] frame_byte
  output logic        m_tlast,
  output logic [1:0]  m_tuser   // [0] frame_done, [1] error
);

  logic accept;
  cmd_t front_cmd;
  cmd_t q_head;
  logic q_full;
  logic q_valid;
  logic q_pop;

  assign s_tready = !q_full;
  assign accept   = s_tvalid && s_tready;

  hcfb_front u_front (
    .clk            (clk),
    .rst            (rst),
    .accept         (accept),
    .kind           (s_tuser),
    .payload_length (s_tdata[7:0]),
    .data_byte      (s_tdata[15:8]),
    .cmd            (front_cmd)
  );

  hcfb_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (accept),
    .push_cmd  (front_cmd),
    .pop       (q_pop),
    .head      (q_head),
    .full      (q_full),
    .not_empty (q_valid)
  );

  hcfb_back u_back (
    .clk      (clk),
    .rst      (rst),
    .q_valid  (q_valid),
    .q_head   (q_head),
    .q_pop    (q_pop),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast),
    .m_tuser  (m_tuser)
  );

endmodule

// ===== rtl/core/hcfb_front.sv =====
// Front end: accepts input transfers, tracks the frame and emits commands.
`timescale 1ns / 1ps

module hcfb_front
  import hcfb_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       accept,
  input  logic       kind,
  input  logic [7:0] payload_length,
  input  logic [7:0] data_byte,
  output cmd_t       cmd
);

  logic       in_frame;
  logic [7:0] bytes_left;
  logic [7:0] running_sum;
  logic       in_frame_next;
  logic [7:0] bytes_left_next;
  logic [7:0] running_sum_next;
  logic [7:0] len_byte;
  logic [7:0] sum_new;

  assign len_byte = payload_length + 8'd1;
  assign sum_new  = running_sum + data_byte;

  always_comb begin
    in_frame_next    = in_frame;
    bytes_left_next  = bytes_left;
    running_sum_next = running_sum;
    cmd.op    = OP_REJECT;
    cmd.value = data_byte;
    cmd.check = twos_neg(sum_new);
    if (!kind) begin
      if (!(in_frame || payload_length == 8'h00 || payload_length == 8'hFF)) begin
        cmd.op           = OP_START;
        cmd.value        = len_byte;
        cmd.check        = twos_neg(len_byte);
        in_frame_next    = 1'b1;
        bytes_left_next  = payload_length;
        running_sum_next = BYTE_DIR;
      end
    end else if (in_frame && bytes_left != 8'h00) begin
      bytes_left_next  = bytes_left - 8'd1;
      running_sum_next = sum_new;
      if (bytes_left == 8'd1) begin
        cmd.op           = OP_LAST;
        in_frame_next    = 1'b0;
        running_sum_next = 8'h00;
      end else begin
        cmd.op = OP_DATA;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_frame    <= 1'b0;
      bytes_left  <= 8'h00;
      running_sum <= 8'h00;
    end else if (accept) begin
      in_frame    <= in_frame_next;
      bytes_left  <= bytes_left_next;
      running_sum <= running_sum_next;
    end
  end

endmodule

// ===== rtl/core/hcfb_queue.sv =====
// Short command queue between the front end and the byte sequencer.
`timescale 1ns / 1ps

module hcfb_queue
  import hcfb_pkg::*;
#(
  parameter int DEPTH = QueueDepthDefault
) (
  input  logic clk,
  input  logic rst,
  input  logic push,
  input  cmd_t push_cmd,
  input  logic pop,
  output cmd_t head,
  output logic full,
  output logic not_empty
);

  localparam int PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CntW = $clog2(DEPTH + 1);

  cmd_t            slots [DEPTH];
  logic [PtrW-1:0] wr_ptr;
  logic [PtrW-1:0] rd_ptr;
  logic [CntW-1:0] count;

  function automatic logic [PtrW-1:0] bump(input logic [PtrW-1:0] p);
    return (p == PtrW'(DEPTH - 1)) ? '0 : p + PtrW'(1);
  endfunction

  assign full      = (count == CntW'(DEPTH));
  assign not_empty = (count != '0);
  assign head      = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= bump(wr_ptr);
      end
      if (pop) begin
        rd_ptr <= bump(rd_ptr);
      end
      if (push && !pop) begin
        count <= count + CntW'(1);
      end else if (pop && !push) begin
        count <= count - CntW'(1);
      end
    end
  end

endmodule

// ===== rtl/core/hcfb_back.sv =====
// Back end: expands each command into frame bytes behind an output register.
`timescale 1ns / 1ps

module hcfb_back
  import hcfb_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       q_valid,
  input  cmd_t       q_head,
  output logic       q_pop,
  output logic       m_tvalid,
  input  logic       m_tready,
  output logic [7:0] m_tdata,
  output logic       m_tlast,
  output logic [1:0] m_tuser
);

  logic            cur_valid;
  cmd_t            cur;
  logic [IdxW-1:0] idx;
  logic            advance;
  logic            have;
  cmd_t            src;
  logic [IdxW-1:0] src_idx;
  res_t            res;

  assign advance = !m_tvalid || m_tready;
  assign have    = cur_valid || q_valid;
  assign src     = cur_valid ? cur : q_head;
  assign src_idx = cur_valid ? idx : '0;
  assign res     = result_of(src, src_idx);
  assign q_pop   = advance && !cur_valid && q_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      cur_valid <= 1'b0;
      m_tvalid  <= 1'b0;
      idx       <= '0;
    end else if (advance) begin
      m_tvalid <= have;
      if (have) begin
        cur_valid <= !res.run_last;
        idx       <= src_idx + IdxW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (advance && have) begin
      cur     <= src;
      m_tdata <= res.frame_byte;
      m_tlast <= res.run_last;
      m_tuser <= {res.error, res.frame_done};
    end
  end

endmodule

// ===== test/host_command_frame_builder_tb.sv =====
// Self-checking testbench for the frame builder: random stream traffic against a predictor.
`timescale 1ns / 1ps

module host_command_frame_builder_tb;
  import hcfb_pkg::*;

  localparam bit KIND_START = 1'b0;
  localparam bit KIND_DATA  = 1'b1;
  localparam logic [7:0] DIR_BYTE = 8'hD4;
  localparam int CALM_TAIL   = 40;
  localparam int DRAIN_WAIT  = 12;
  localparam int CYCLE_LIMIT = 300000;

  typedef struct packed {
    bit       kind;
    bit [7:0] payload_length;
    bit [7:0] data_byte;
  } cmd_item_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [15:0] s_tdata = '0;  // [7:0] payload_length, [15:8] data_byte
  logic        s_tuser = 1'b0;  // [0] kind
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [7:0]  m_tdata;  // [7:0] frame_byte
  logic        m_tlast;
  logic [1:0]  m_tuser;  // [0] frame_done, [1] error

  cmd_item_t cmd_items_pending[$];
  res_t      frame_bytes_due[$];
  cmd_item_t cmd_on_bus;
  int        src_gap = 0;
  int        sink_gap = 0;
  int        mismatch_count = 0;
  int        cycle_count = 0;

  bit        open_frame = 1'b0;
  bit [7:0]  bytes_owed = '0;
  bit [7:0]  data_sum = '0;

  host_command_frame_builder u_dut (
    .clk     (clk),
    .rst     (rst),
    .s_tvalid(s_tvalid),
    .s_tready(s_tready),
    .s_tdata (s_tdata),
    .s_tuser (s_tuser),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .m_tdata (m_tdata),
    .m_tlast (m_tlast),
    .m_tuser (m_tuser)
  );

  initial begin
    forever #1 clk = ~clk;
  end

  function automatic res_t frame_res(bit [7:0] b, bit last, bit done, bit err);
    res_t r;
    r.frame_byte = b;
    r.run_last   = last;
    r.frame_done = done;
    r.error      = err;
    return r;
  endfunction

  task automatic build_frame_bytes(input cmd_item_t it);
    bit [7:0] len_byte;
    if (it.kind == KIND_START) begin
      if (open_frame || it.payload_length == 8'h00 || it.payload_length == 8'hFF) begin
        frame_bytes_due.push_back(frame_res(8'h00, 1'b1, 1'b0, 1'b1));
      end else begin
        len_byte = it.payload_length + 8'd1;
        frame_bytes_due.push_back(frame_res(8'h00, 1'b0, 1'b0, 1'b0));
        frame_bytes_due.push_back(frame_res(8'h00, 1'b0, 1'b0, 1'b0));
        frame_bytes_due.push_back(frame_res(8'hFF, 1'b0, 1'b0, 1'b0));
        frame_bytes_due.push_back(frame_res(len_byte, 1'b0, 1'b0, 1'b0));
        frame_bytes_due.push_back(frame_res(8'h00 - len_byte, 1'b0, 1'b0, 1'b0));
        frame_bytes_due.push_back(frame_res(DIR_BYTE, 1'b1, 1'b0, 1'b0));
        open_frame = 1'b1;
        bytes_owed = it.payload_length;
        data_sum   = DIR_BYTE;
      end
    end else if (!open_frame || bytes_owed == 8'h00) begin
      frame_bytes_due.push_back(frame_res(8'h00, 1'b1, 1'b0, 1'b1));
    end else begin
      data_sum   = data_sum + it.data_byte;
      bytes_owed = bytes_owed - 8'd1;
      if (bytes_owed != 8'h00) begin
        frame_bytes_due.push_back(frame_res(it.data_byte, 1'b1, 1'b0, 1'b0));
      end else begin
        frame_bytes_due.push_back(frame_res(it.data_byte, 1'b0, 1'b0, 1'b0));
        frame_bytes_due.push_back(frame_res(8'h00 - data_sum, 1'b0, 1'b0, 1'b0));
        frame_bytes_due.push_back(frame_res(8'h00, 1'b1, 1'b1, 1'b0));
        open_frame = 1'b0;
        data_sum   = 8'h00;
      end
    end
  endtask

  function automatic void push_cmd(bit kind, bit [7:0] plen, bit [7:0] dbyte);
    cmd_item_t it;
    it.kind = kind;
    it.payload_length = plen;
    it.data_byte = dbyte;
    cmd_items_pending.push_back(it);
  endfunction

  function automatic void push_frame(int len, bit noisy);
    push_cmd(KIND_START, 8'(len), 8'($urandom));
    for (int i = 0; i < len; i++) begin
      if (noisy && $urandom_range(0, 5) == 0) begin
        push_cmd(KIND_START, 8'($urandom), 8'($urandom));
      end
      push_cmd(KIND_DATA, 8'($urandom), 8'($urandom));
    end
  endfunction

  always @(posedge clk) begin
    if (rst) begin
      s_tvalid <= 1'b0;
      src_gap = 0;
    end else begin
      if (s_tvalid && s_tready) begin
        build_frame_bytes(cmd_on_bus);
      end
      if (!s_tvalid || s_tready) begin
        if (src_gap > 0) begin
          src_gap--;
          s_tvalid <= 1'b0;
        end else if (cmd_items_pending.size() > 0) begin
          cmd_on_bus = cmd_items_pending.pop_front();
          s_tvalid <= 1'b1;
          s_tdata  <= {cmd_on_bus.data_byte, cmd_on_bus.payload_length};
          s_tuser  <= cmd_on_bus.kind;
          if (cmd_items_pending.size() > CALM_TAIL && $urandom_range(0, 5) == 0) begin
            src_gap = $urandom_range(1, 3);
          end
        end else begin
          s_tvalid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk) begin
    res_t want;
    if (rst) begin
      m_tready <= 1'b0;
      sink_gap = 0;
    end else begin
      if (m_tvalid && m_tready) begin
        if (frame_bytes_due.size() == 0) begin
          $error("unexpected transfer: frame_byte %h tlast %b tuser %b", m_tdata, m_tlast,
                 m_tuser);
          mismatch_count++;
        end else begin
          want = frame_bytes_due.pop_front();
          if (m_tdata !== want.frame_byte) begin
            $error("frame_byte: expected %h, actual %h", want.frame_byte, m_tdata);
            mismatch_count++;
          end
          if (m_tlast !== want.run_last) begin
            $error("run_last: expected %b, actual %b", want.run_last, m_tlast);
            mismatch_count++;
          end
          if (m_tuser[0] !== want.frame_done) begin
            $error("frame_done: expected %b, actual %b", want.frame_done, m_tuser[0]);
            mismatch_count++;
          end
          if (m_tuser[1] !== want.error) begin
            $error("error: expected %b, actual %b", want.error, m_tuser[1]);
            mismatch_count++;
          end
        end
      end
      if (sink_gap > 0) begin
        sink_gap--;
        m_tready <= 1'b0;
      end else begin
        m_tready <= 1'b1;
        if (cmd_items_pending.size() > CALM_TAIL && $urandom_range(0, 5) == 0) begin
          sink_gap = $urandom_range(1, 3);
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  initial begin
    int sel;
    int len;
    int long_at;
    // Directed opening: rejections from the idle state, the smallest frame, a start
    // inside an open frame, extreme data bytes and the largest rejected length.
    push_cmd(KIND_DATA, 8'hFF, 8'hFF);
    push_cmd(KIND_START, 8'h00, 8'hFF);
    push_cmd(KIND_START, 8'hFF, 8'h00);
    push_cmd(KIND_START, 8'h01, 8'h00);
    push_cmd(KIND_START, 8'h05, 8'hFF);
    push_cmd(KIND_DATA, 8'hFF, 8'h00);
    push_cmd(KIND_DATA, 8'h00, 8'hFF);
    push_cmd(KIND_START, 8'h03, 8'h5A);
    push_cmd(KIND_DATA, 8'hA5, 8'hFF);
    push_cmd(KIND_START, 8'hFF, 8'hFF);
    push_cmd(KIND_START, 8'h00, 8'h00);
    push_cmd(KIND_DATA, 8'h5A, 8'hFF);
    push_cmd(KIND_DATA, 8'hC3, 8'h2C);
    push_cmd(KIND_DATA, 8'h3C, 8'h80);
    push_cmd(KIND_START, 8'h02, 8'h01);
    push_cmd(KIND_DATA, 8'h00, 8'h00);
    push_cmd(KIND_DATA, 8'hFF, 8'h00);

    long_at = $urandom_range(20, 250);
    while (cmd_items_pending.size() < 305) begin
      if (cmd_items_pending.size() >= long_at && long_at > 0) begin
        push_frame(254, 1'b0);
        long_at = 0;
      end
      sel = $urandom_range(0, 9);
      if (sel < 8) begin
        len = ($urandom_range(0, 7) == 0) ? $urandom_range(7, 40) : $urandom_range(1, 6);
        push_frame(len, sel == 7);
      end else if (sel == 8) begin
        push_cmd(KIND_DATA, 8'($urandom), 8'($urandom));
      end else begin
        push_cmd(KIND_START, $urandom_range(0, 1) ? 8'hFF : 8'h00, 8'($urandom));
      end
    end
    if (long_at > 0) begin
      push_frame(254, 1'b0);
    end

    repeat (6) @(posedge clk);
    rst <= 1'b0;

    @(posedge clk);
    while (cmd_items_pending.size() != 0 || s_tvalid || frame_bytes_due.size() != 0) begin
      @(posedge clk);
    end
    repeat (DRAIN_WAIT) @(posedge clk);
    if (frame_bytes_due.size() != 0) begin
      $error("frame_bytes_due: expected 0 left, actual %0d", frame_bytes_due.size());
      mismatch_count++;
    end
    if (mismatch_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
